[sv/tlrq_pkg.sv]
// Shared constants, codes and types for the three-level ready queue.
// No dependencies; the control and top-level files take names from here by scope.
`default_nettype none

package tlrq_pkg;

	localparam int NUM_LEVELS      = 3;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int PID_BITS_DEF    = 8;
	localparam int PID_FIELD_W     = 8;

	// command codes
	localparam logic [1:0] CMD_INSERT  = 2'd0;
	localparam logic [1:0] CMD_PREEMPT = 2'd1;
	localparam logic [1:0] CMD_POP     = 2'd2;

	// status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_DROP  = 2'd2;

	// result info handed from the control stage to the output stage
	typedef struct packed {
		logic       pop_hit;
		logic [1:0] level;
		logic [1:0] status;
	} rslt_t;

endpackage

`default_nettype wire

[sv/tlrq_if.sv]
// Valid/ready channel interfaces for the command and result words.
// Depends on: nothing.
`default_nettype none

interface tlrq_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [1:0] level;
	logic [7:0] pid_in;

	modport source (output valid, cmd, level, pid_in, input ready);
	modport sink   (input valid, cmd, level, pid_in, output ready);
endinterface

interface tlrq_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] pid_out;
	logic [1:0] pid_level;
	logic [1:0] status;

	modport source (output valid, pid_out, pid_level, status, input ready);
	modport sink   (input valid, pid_out, pid_level, status, output ready);
endinterface

`default_nettype wire

[sv/tlrq_mem.sv]
// Single-port entry store with registered read data, one access per cycle.
// Depends on: nothing.
`default_nettype none

module tlrq_mem #(
	parameter int DEPTH = 48,
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

`default_nettype wire

[sv/tlrq_ctrl.sv]
// Head and count registers per level; decodes a command word into one
// store access and the result info. Depends on: tlrq_pkg.
`default_nettype none

module tlrq_ctrl #(
	parameter int QUEUE_DEPTH = tlrq_pkg::QUEUE_DEPTH_DEF,
	parameter int SW          = 8,
	localparam int AW = $clog2(tlrq_pkg::NUM_LEVELS * QUEUE_DEPTH)
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire logic [1:0]      cmd,
	input  wire logic [1:0]      level,
	input  wire logic [SW-1:0]   pid,
	output logic                 mem_en,
	output logic                 mem_we,
	output logic      [AW-1:0]   mem_addr,
	output logic      [SW-1:0]   mem_wdata,
	output tlrq_pkg::rslt_t      rslt
);

	localparam int NL = tlrq_pkg::NUM_LEVELS;
	localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [HW-1:0] head_q  [NL];
	logic [CW-1:0] count_q [NL];
	logic [HW-1:0] head_d  [NL];
	logic [CW-1:0] count_d [NL];

	logic [HW-1:0] tail   [NL];
	logic [HW-1:0] h_dec  [NL];
	logic [HW-1:0] h_inc  [NL];
	logic [AW-1:0] base   [NL];
	logic [CW:0]   sum    [NL];
	logic          nonempty [NL];

	logic       lvl_ok;
	logic [1:0] lvl_idx;
	logic       full;
	logic [1:0] pop_lvl;

	// per-level slot arithmetic, independent for each level
	always_comb begin
		for (int l = 0; l < NL; l++) begin
			sum[l]      = (CW+1)'(head_q[l]) + (CW+1)'(count_q[l]);
			tail[l]     = (sum[l] >= (CW+1)'(QUEUE_DEPTH))
			              ? HW'(sum[l] - (CW+1)'(QUEUE_DEPTH)) : HW'(sum[l]);
			h_dec[l]    = (head_q[l] == '0) ? HW'(QUEUE_DEPTH - 1) : head_q[l] - 1'b1;
			h_inc[l]    = (head_q[l] == HW'(QUEUE_DEPTH - 1)) ? '0 : head_q[l] + 1'b1;
			base[l]     = AW'(l * QUEUE_DEPTH);
			nonempty[l] = (count_q[l] != '0);
		end
	end

	assign lvl_ok  = (level < 2'(NL));
	assign lvl_idx = lvl_ok ? level : 2'd0;
	assign full    = (count_q[lvl_idx] == CW'(QUEUE_DEPTH));
	assign pop_lvl = nonempty[0] ? 2'd0 : (nonempty[1] ? 2'd1 : 2'd2);

	always_comb begin
		mem_en    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = '0;
		mem_wdata = pid;
		head_d    = head_q;
		count_d   = count_q;
		rslt      = '{pop_hit: 1'b0, level: 2'd0, status: tlrq_pkg::ST_DONE};
		if (accept) begin
			unique case (cmd) inside
				tlrq_pkg::CMD_INSERT, tlrq_pkg::CMD_PREEMPT: begin
					if (!lvl_ok || full) begin
						rslt.status = tlrq_pkg::ST_DROP;
					end else begin
						mem_en = 1'b1;
						mem_we = 1'b1;
						if (cmd == tlrq_pkg::CMD_INSERT) begin
							mem_addr = base[lvl_idx] + AW'(tail[lvl_idx]);
						end else begin
							head_d[lvl_idx] = h_dec[lvl_idx];
							mem_addr = base[lvl_idx] + AW'(h_dec[lvl_idx]);
						end
						count_d[lvl_idx] = count_q[lvl_idx] + 1'b1;
					end
				end
				tlrq_pkg::CMD_POP: begin
					if (nonempty[0] || nonempty[1] || nonempty[2]) begin
						mem_en = 1'b1;
						mem_addr = base[pop_lvl] + AW'(head_q[pop_lvl]);
						head_d[pop_lvl]  = h_inc[pop_lvl];
						count_d[pop_lvl] = count_q[pop_lvl] - 1'b1;
						rslt.pop_hit = 1'b1;
						rslt.level   = pop_lvl;
					end else begin
						rslt.status = tlrq_pkg::ST_EMPTY;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < NL; l++) begin
				head_q[l]  <= '0;
				count_q[l] <= '0;
			end
		end else begin
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	// occupancy never exceeds the level depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q[0] <= CW'(QUEUE_DEPTH) && count_q[1] <= CW'(QUEUE_DEPTH) &&
		count_q[2] <= CW'(QUEUE_DEPTH))
		else $error("level count above depth");

	// an accepted enqueue grows exactly its own level by one
	a_enq_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (cmd == tlrq_pkg::CMD_INSERT || cmd == tlrq_pkg::CMD_PREEMPT)
		&& lvl_ok && !full
		|=> count_q[$past(lvl_idx)] == $past(count_q[lvl_idx]) + 1'b1)
		else $error("enqueue did not bump count");

	// a pop that finds nothing leaves every level empty
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd == tlrq_pkg::CMD_POP && !nonempty[0] && !nonempty[1] && !nonempty[2]
		|=> !nonempty[0] && !nonempty[1] && !nonempty[2])
		else $error("empty pop changed state");

endmodule

`default_nettype wire

[sv/three_level_ready_queue.sv]
// Top level of the three-level ready queue: control, entry store and
// output register. Depends on: tlrq_pkg, tlrq_if, tlrq_ctrl, tlrq_mem.
//
//  port  | dir | word                              | accepted when
//  ------+-----+-----------------------------------+----------------------
//  req   | in  | cmd, level, pid_in                | req.valid & req.ready
//  rsp   | out | pid_out, pid_level, status        | rsp.valid & rsp.ready
//
// One command word per cycle while req.ready is high. Each word touches one
// end of one level, so the store sees at most one access per word; a result
// word passes the stage behind the store, for the store read, and then the
// output register on its way to rsp. req.ready drops only while both the stage
// behind the store and the output register are full and rsp is stalled.
// Reset clears heads and counts at once; the store needs no clearing.
`default_nettype none

module three_level_ready_queue #(
	parameter int QUEUE_DEPTH = tlrq_pkg::QUEUE_DEPTH_DEF,
	parameter int PID_BITS    = tlrq_pkg::PID_BITS_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	tlrq_in_if.sink   req,
	tlrq_out_if.source rsp
);

	// the pid field is 8 bits wide, so no more than 8 bits are ever kept
	localparam int SW    = (PID_BITS < tlrq_pkg::PID_FIELD_W) ? PID_BITS
	                        : tlrq_pkg::PID_FIELD_W;
	localparam int DEPTH = tlrq_pkg::NUM_LEVELS * QUEUE_DEPTH;
	localparam int AW    = $clog2(DEPTH);

	logic            accept;
	logic            mem_en;
	logic            mem_we;
	logic [AW-1:0]   mem_addr;
	logic [SW-1:0]   mem_wdata;
	logic [SW-1:0]   mem_rdata;
	tlrq_pkg::rslt_t rslt;

	// stage behind the store: holds result info while read data settles
	logic            valid_s1;
	tlrq_pkg::rslt_t rslt_s1;
	logic            adv_s1;

	// output register
	logic       out_valid_q;
	logic [7:0] out_pid_q;
	logic [1:0] out_level_q;
	logic [1:0] out_status_q;

	assign adv_s1    = !out_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || adv_s1;
	assign accept    = req.valid && req.ready;

	tlrq_ctrl #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.SW          (SW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.cmd       (req.cmd),
		.level     (req.level),
		.pid       (req.pid_in[SW-1:0]),
		.mem_en    (mem_en),
		.mem_we    (mem_we),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.rslt      (rslt)
	);

	// read data is only refreshed on an accepted pop, so it holds while
	// the stage behind it stalls
	tlrq_mem #(
		.DEPTH (DEPTH),
		.WIDTH (SW)
	) u_mem (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= accept;
			end
			if (adv_s1) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rslt_s1 <= rslt;
		end
		if (adv_s1 && valid_s1) begin
			out_pid_q    <= rslt_s1.pop_hit ? 8'(mem_rdata) : 8'd0;
			out_level_q  <= rslt_s1.level;
			out_status_q <= rslt_s1.status;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.pid_out   = out_pid_q;
	assign rsp.pid_level = out_level_q;
	assign rsp.status    = out_status_q;

	// both stages full and output stalled: no new command may enter
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !rsp.ready |-> !req.ready)
		else $error("command taken while pipeline full");

	// a stalled stage behind the store keeps its result info
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(rslt_s1))
		else $error("stalled stage lost its word");

	// the store is read only for a pop that found an entry
	a_read_pop: assert property (@(posedge clk) disable iff (!arst_n)
		mem_en && !mem_we |-> accept && rslt.pop_hit)
		else $error("store read without a pop");

endmodule

`default_nettype wire
